### design/lsqzi_pkg.sv
// ----------------------------------------------------------------------------
// Least-squares zero-intercept fit: shared package
// Default sizes, code names and the command/status bundles that run between
// the controller and the datapath.
// ----------------------------------------------------------------------------
package lsqzi_pkg;

  localparam int unsigned MaxPointsDef = 64;
  localparam int unsigned AdcBitsDef   = 24;
  localparam int unsigned DacBitsDef   = 20;

  // range_select codes
  localparam logic [1:0] RANGE_ALL    = 2'd0;
  localparam logic [1:0] RANGE_FIRST  = 2'd1;
  localparam logic [1:0] RANGE_SECOND = 2'd2;

  // fit_status codes
  localparam logic [1:0] FIT_OK       = 2'd0;
  localparam logic [1:0] FIT_FEW      = 2'd1;
  localparam logic [1:0] FIT_ZERO_DEN = 2'd2;

  // products worked by the shared serial multiplier, in issue order
  typedef enum logic [1:0] {
    OP_N_SX2   = 2'd0,  // acc  = n  * sx2
    OP_SX_SX   = 2'd1,  // acc -= sx * sx   (denominator)
    OP_SY_SX2  = 2'd2,  // acc  = sy * sx2
    OP_SX_SXY  = 2'd3   // acc -= sx * sxy  (numerator)
  } mul_op_e;

  typedef struct packed {
    logic    fit_init;
    logic    rd_en;
    logic    mul_start;
    mul_op_e mul_op;
    logic    div_start;
    logic    res_load;
  } cmd_t;

  typedef struct packed {
    logic walk_done;
    logic pipe_busy;
    logic mul_busy;
    logic div_busy;
    logic out_valid;
  } sts_t;

endpackage

### design/lsqzi_ctrl.sv
// ----------------------------------------------------------------------------
// Least-squares zero-intercept fit: controller
// Sequences the store walk, the four serial products and the division.
// ----------------------------------------------------------------------------
module lsqzi_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              last_point_i,
  output logic              in_stall_o,
  input  lsqzi_pkg::sts_t   sts_i,
  output lsqzi_pkg::cmd_t   cmd_o
);
  import lsqzi_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_WALK     = 7'b0000010,
    S_DRAIN    = 7'b0000100,
    S_MUL_GO   = 7'b0001000,
    S_MUL_WAIT = 7'b0010000,
    S_DIV_GO   = 7'b0100000,
    S_DIV_WAIT = 7'b1000000
  } state_e;

  state_e  state_q, state_d;
  mul_op_e op_q, op_d;
  logic    accept;

  // Hold the input while fitting, and hold a last item while a result waits
  assign in_stall_o = (state_q != S_IDLE) || (sts_i.out_valid && last_point_i);
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (accept && last_point_i) begin
          cmd_o.fit_init = 1'b1;
          state_d        = S_WALK;
        end
      end
      S_WALK: begin
        if (sts_i.walk_done) begin
          state_d = S_DRAIN;
        end else begin
          cmd_o.rd_en = 1'b1;
        end
      end
      S_DRAIN: begin
        if (!sts_i.pipe_busy) begin
          op_d    = OP_N_SX2;
          state_d = S_MUL_GO;
        end
      end
      S_MUL_GO: begin
        cmd_o.mul_start = 1'b1;
        cmd_o.mul_op    = op_q;
        state_d         = S_MUL_WAIT;
      end
      S_MUL_WAIT: begin
        if (!sts_i.mul_busy) begin
          if (op_q == OP_SX_SXY) begin
            state_d = S_DIV_GO;
          end else begin
            op_d    = mul_op_e'(op_q + 2'd1);
            state_d = S_MUL_GO;
          end
        end
      end
      S_DIV_GO: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (!sts_i.div_busy) begin
          cmd_o.res_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      op_q    <= OP_N_SX2;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
    end
  end

endmodule

### design/lsqzi_datapath.sv
// ----------------------------------------------------------------------------
// Least-squares zero-intercept fit: datapath
// Point store, walk pipeline with sums, serial multiplier, restoring divider
// and the result register.
// ----------------------------------------------------------------------------
module lsqzi_datapath #(
  parameter int unsigned MAX_POINTS = lsqzi_pkg::MaxPointsDef,
  parameter int unsigned ADC_BITS   = lsqzi_pkg::AdcBitsDef,
  parameter int unsigned DAC_BITS   = lsqzi_pkg::DacBitsDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_accept_i,
  input  logic signed [ADC_BITS-1:0] adc_sample_i,
  input  logic signed [DAC_BITS-1:0] dac_code_i,
  input  logic                       cfg_we_i,
  input  logic [1:0]                 cfg_wdata_i,
  input  logic                       out_stall_i,
  input  lsqzi_pkg::cmd_t            cmd_i,
  output lsqzi_pkg::sts_t            sts_o,
  output logic                       out_valid_o,
  output logic signed [31:0]         intercept_o,
  output logic [1:0]                 fit_status_o,
  output logic [6:0]                 points_used_o,
  output logic                       store_overflow_o
);
  import lsqzi_pkg::*;

  localparam int unsigned CW   = $clog2(MAX_POINTS + 1);
  localparam int unsigned AIW  = $clog2(MAX_POINTS);
  localparam int unsigned PTW  = ADC_BITS + DAC_BITS;
  localparam int unsigned SXW  = ADC_BITS + CW;
  localparam int unsigned SX2W = 2 * ADC_BITS + CW;
  localparam int unsigned SYW  = DAC_BITS + CW;
  localparam int unsigned SXYW = ADC_BITS + DAC_BITS + CW;
  localparam int unsigned MBW  = (SXW > SYW) ? SXW : SYW;
  localparam int unsigned MBW1 = MBW + 1;
  localparam int unsigned MCW  = $clog2(MBW + 1);
  localparam int unsigned AW   = 2 * ADC_BITS + DAC_BITS + 2 * CW + 1;
  localparam int unsigned RW   = AW + 1;
  localparam int unsigned NW   = AW + 8;
  localparam int unsigned DCW  = $clog2(NW + 1);
  localparam int unsigned P2W  = 2 * ADC_BITS;

  // point store and set bookkeeping
  logic [PTW-1:0] mem [MAX_POINTS];
  logic [PTW-1:0] rd_data_q;
  logic [CW-1:0]  count_q, count_nx, half;
  logic           ovf_q, ovf_nx, full;
  logic [1:0]     range_q;

  // fit range and walk
  logic [CW-1:0]  n_q, left_q;
  logic [AIW-1:0] addr_q;
  logic           ovf_fit_q;
  logic           rv_q, pv_q;
  logic signed [ADC_BITS-1:0] x_q;
  logic signed [DAC_BITS-1:0] y_q;
  logic signed [P2W-1:0]      px2_q;
  logic signed [PTW-1:0]      pxy_q;
  logic signed [SXW-1:0]      sum_adc_q;
  logic signed [SX2W-1:0]     sum_adc_squared_q;
  logic signed [SYW-1:0]      sum_dac_q;
  logic signed [SXYW-1:0]     sum_adc_dac_q;

  // serial multiplier
  logic signed [AW-1:0]   mul_a, mcand_q, acc_q, den_q;
  logic signed [MBW1-1:0] mul_b, b_mag;
  logic [MBW-1:0]         mplier_q;
  logic [MCW-1:0]         mul_left_q;
  logic                   mul_neg_q;

  // divider
  logic [NW-1:0]  quo_q;
  logic [AW-1:0]  dvs_q, num_mag, den_mag;
  logic [AW-1:0]  rem_q;
  logic [RW-1:0]  rem_sh;
  logic           rem_ge, div_neg_q;
  logic [DCW-1:0] div_left_q;

  // result register
  logic        out_valid_q;
  logic [31:0] icpt_q, icpt_d;
  logic [1:0]  status_q, status_d;
  logic [6:0]  used_q;
  logic        ovf_out_q;
  logic        sat_pos, sat_neg;

  // Load side: count the point or note the drop
  assign full     = (count_q == CW'(MAX_POINTS));
  assign count_nx = (in_accept_i && !full) ? count_q + 1'b1 : count_q;
  assign ovf_nx   = ovf_q || (in_accept_i && full);
  assign half     = count_nx >> 1;

  always_ff @(posedge clk_i) begin
    if (in_accept_i && !full) begin
      mem[count_q[AIW-1:0]] <= {adc_sample_i, dac_code_i};
    end
    if (cmd_i.rd_en) begin
      rd_data_q <= mem[addr_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      ovf_q   <= 1'b0;
      range_q <= RANGE_ALL;
    end else begin
      if (cfg_we_i) begin
        range_q <= cfg_wdata_i;
      end
      if (cmd_i.fit_init) begin
        count_q <= '0;
        ovf_q   <= 1'b0;
      end else begin
        count_q <= count_nx;
        ovf_q   <= ovf_nx;
      end
    end
  end

  // Walk the fit range: read, multiply, accumulate
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q <= '0;
      rv_q   <= 1'b0;
      pv_q   <= 1'b0;
    end else begin
      rv_q <= cmd_i.rd_en;
      pv_q <= rv_q;
      if (cmd_i.fit_init) begin
        left_q <= (range_q == RANGE_FIRST || range_q == RANGE_SECOND) ? half : count_nx;
      end else if (cmd_i.rd_en) begin
        left_q <= left_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fit_init) begin
      n_q       <= (range_q == RANGE_FIRST || range_q == RANGE_SECOND) ? half : count_nx;
      addr_q    <= (range_q == RANGE_SECOND) ? AIW'(half) : '0;
      ovf_fit_q <= ovf_nx;
      sum_adc_q         <= '0;
      sum_adc_squared_q <= '0;
      sum_dac_q         <= '0;
      sum_adc_dac_q     <= '0;
    end else begin
      if (cmd_i.rd_en) begin
        addr_q <= addr_q + 1'b1;
      end
      if (pv_q) begin
        sum_adc_q         <= sum_adc_q + SXW'(x_q);
        sum_adc_squared_q <= sum_adc_squared_q + SX2W'(px2_q);
        sum_dac_q         <= sum_dac_q + SYW'(y_q);
        sum_adc_dac_q     <= sum_adc_dac_q + SXYW'(pxy_q);
      end
    end
    if (rv_q) begin
      x_q   <= $signed(rd_data_q[PTW-1:DAC_BITS]);
      y_q   <= $signed(rd_data_q[DAC_BITS-1:0]);
      px2_q <= $signed(rd_data_q[PTW-1:DAC_BITS]) * $signed(rd_data_q[PTW-1:DAC_BITS]);
      pxy_q <= $signed(rd_data_q[PTW-1:DAC_BITS]) * $signed(rd_data_q[DAC_BITS-1:0]);
    end
  end

  // Pick the operands of the product to start
  always_comb begin
    case (cmd_i.mul_op)
      OP_N_SX2: begin
        mul_a = AW'(sum_adc_squared_q);
        mul_b = MBW1'($signed({1'b0, n_q}));
      end
      OP_SX_SX: begin
        mul_a = AW'(sum_adc_q);
        mul_b = MBW1'(sum_adc_q);
      end
      OP_SY_SX2: begin
        mul_a = AW'(sum_adc_squared_q);
        mul_b = MBW1'(sum_dac_q);
      end
      default: begin
        mul_a = AW'(sum_adc_dac_q);
        mul_b = MBW1'(sum_adc_q);
      end
    endcase
  end

  assign b_mag = mul_b[MBW] ? -mul_b : mul_b;

  // Serial shift-add multiply, one multiplier bit a cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_left_q <= '0;
    end else if (cmd_i.mul_start) begin
      mul_left_q <= MCW'(MBW);
    end else if (mul_left_q != '0) begin
      mul_left_q <= mul_left_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_start) begin
      mcand_q   <= mul_a;
      mplier_q  <= b_mag[MBW-1:0];
      mul_neg_q <= mul_b[MBW] ^ (cmd_i.mul_op == OP_SX_SX || cmd_i.mul_op == OP_SX_SXY);
      if (cmd_i.mul_op == OP_N_SX2 || cmd_i.mul_op == OP_SY_SX2) begin
        acc_q <= '0;
      end
      if (cmd_i.mul_op == OP_SY_SX2) begin
        den_q <= acc_q;
      end
    end else if (mul_left_q != '0) begin
      if (mplier_q[0]) begin
        acc_q <= mul_neg_q ? acc_q - mcand_q : acc_q + mcand_q;
      end
      mcand_q  <= mcand_q <<< 1;
      mplier_q <= mplier_q >> 1;
    end
  end

  // Restoring division of |num| * 256 by |den|, one quotient bit a cycle
  assign num_mag = acc_q[AW-1] ? AW'(-acc_q) : AW'(acc_q);
  assign den_mag = den_q[AW-1] ? AW'(-den_q) : AW'(den_q);
  assign rem_sh  = {rem_q, quo_q[NW-1]};
  assign rem_ge  = rem_sh >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_left_q <= '0;
    end else if (cmd_i.div_start) begin
      div_left_q <= DCW'(NW);
    end else if (div_left_q != '0) begin
      div_left_q <= div_left_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      quo_q     <= {num_mag, 8'd0};
      dvs_q     <= den_mag;
      rem_q     <= '0;
      div_neg_q <= acc_q[AW-1] ^ den_q[AW-1];
    end else if (div_left_q != '0) begin
      rem_q <= rem_ge ? AW'(rem_sh - {1'b0, dvs_q}) : AW'(rem_sh);
      quo_q <= {quo_q[NW-2:0], rem_ge};
    end
  end

  // Saturate the quotient and classify the fit
  assign sat_pos = (quo_q[NW-1:31] != '0);
  assign sat_neg = (quo_q[NW-1:32] != '0) || (quo_q[31] && quo_q[30:0] != '0);

  always_comb begin
    icpt_d   = '0;
    status_d = FIT_OK;
    if (n_q < CW'(2)) begin
      status_d = FIT_FEW;
    end else if (den_q == '0) begin
      status_d = FIT_ZERO_DEN;
    end else if (!div_neg_q) begin
      icpt_d = sat_pos ? 32'h7FFF_FFFF : quo_q[31:0];
    end else begin
      icpt_d = sat_neg ? 32'h8000_0000 : -quo_q[31:0];
    end
  end

  // Result register: hold until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.res_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      icpt_q    <= icpt_d;
      status_q  <= status_d;
      used_q    <= 7'(n_q);
      ovf_out_q <= ovf_fit_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign intercept_o      = $signed(icpt_q);
  assign fit_status_o     = status_q;
  assign points_used_o    = used_q;
  assign store_overflow_o = ovf_out_q;

  assign sts_o.walk_done = (left_q == '0);
  assign sts_o.pipe_busy = rv_q || pv_q;
  assign sts_o.mul_busy  = (mul_left_q != '0);
  assign sts_o.div_busy  = (div_left_q != '0);
  assign sts_o.out_valid = out_valid_q;

endmodule

### design/least_squares_zero_intercept.sv
// Loading: a point is taken whenever no fit is running, but a last point is
// held while a result waits. Fit after the last point: the walk of the range,
// four serial products over MBW bits (MBW = ADC_BITS + clog2(MAX_POINTS+1) at
// default sizes, 31), then the one-bit-a-cycle divider over NW bits (NW =
// 2*ADC_BITS + DAC_BITS + 2*clog2(MAX_POINTS+1) + 9, 91 at defaults).
// Reset clears the set, the range register and the result; the store needs none.
// ----------------------------------------------------------------------------
// Least-squares zero-intercept fit: top level
// Stores a set of (ADC, DAC) points and fits the DAC code at zero ADC.
// ----------------------------------------------------------------------------
module least_squares_zero_intercept #(
  parameter int unsigned MAX_POINTS = lsqzi_pkg::MaxPointsDef,
  parameter int unsigned ADC_BITS   = lsqzi_pkg::AdcBitsDef,
  parameter int unsigned DAC_BITS   = lsqzi_pkg::DacBitsDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic signed [ADC_BITS-1:0] adc_sample_i,
  input  logic signed [DAC_BITS-1:0] dac_code_i,
  input  logic                       last_point_i,
  input  logic                       cfg_we_i,
  input  logic [1:0]                 cfg_wdata_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic signed [31:0]         intercept_o,
  output logic [1:0]                 fit_status_o,
  output logic [6:0]                 points_used_o,
  output logic                       store_overflow_o
);
  import lsqzi_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic in_accept;

  assign in_accept = in_valid_i && !in_stall_o;

  lsqzi_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .last_point_i (last_point_i),
    .in_stall_o   (in_stall_o),
    .sts_i        (sts),
    .cmd_o        (cmd)
  );

  lsqzi_datapath #(
    .MAX_POINTS (MAX_POINTS),
    .ADC_BITS   (ADC_BITS),
    .DAC_BITS   (DAC_BITS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_accept_i      (in_accept),
    .adc_sample_i     (adc_sample_i),
    .dac_code_i       (dac_code_i),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .out_stall_i      (out_stall_i),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .out_valid_o      (out_valid_o),
    .intercept_o      (intercept_o),
    .fit_status_o     (fit_status_o),
    .points_used_o    (points_used_o),
    .store_overflow_o (store_overflow_o)
  );

endmodule

### design/lsqzi_checker.sv
// ----------------------------------------------------------------------------
// Least-squares zero-intercept fit: port checker
// Watches the top-level ports over time; attached by bind.
// ----------------------------------------------------------------------------
module lsqzi_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        last_point_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] intercept_o,
  input logic [1:0]  fit_status_o
);
  import lsqzi_pkg::*;

  // a stalled result item holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(intercept_o))
    else $error("stalled result changed");

  // failed fits report a zero intercept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (fit_status_o == FIT_FEW || fit_status_o == FIT_ZERO_DEN)
      |-> intercept_o == '0)
    else $error("failed fit with non-zero intercept");

  // status code always meaningful
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> fit_status_o != 2'd3)
    else $error("undefined fit status");

  // a last item is never taken while a result waits, and its fit takes time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && last_point_i |-> !out_valid_o ##1 !out_valid_o)
    else $error("fit result too early or overlapping");

endmodule

bind least_squares_zero_intercept lsqzi_checker u_lsqzi_checker (.*);

### tb/testbench.sv
// ----------------------------------------------------------------------------
// Least-squares zero-intercept fit: testbench
// Loads sets of (ADC, DAC) points and, on each last point, predicts the fitted
// intercept, status, points used and overflow flag. Results are compared
// in order with a scoreboard. Sender and receiver idle at random in phases.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import lsqzi_pkg::*;

  localparam int unsigned NPTS = MaxPointsDef;

  typedef struct packed {
    logic signed [31:0] icpt;
    logic [1:0]         status;
    logic [6:0]         used;
    logic               ovf;
  } fit_res_t;

  // Scoreboard: holds the set being loaded and the fits still to arrive
  class fit_scoreboard;
    logic signed [23:0] adc_mem[NPTS];
    logic signed [19:0] dac_mem[NPTS];
    int unsigned        count;
    bit                 ovf;
    logic [1:0]         sel;
    fit_res_t           pending[$];
    int unsigned        errors;

    function void clear_set();
      count = 0;
      ovf   = 0;
    endfunction

    function fit_res_t compute_fit();
      fit_res_t r;
      int unsigned start, n;
      logic signed [127:0] sx, sx2, sy, sxy, x, y, den, num, q;
      bit neg;
      sx = 0; sx2 = 0; sy = 0; sxy = 0;
      n = count;
      start = 0;
      if (sel == RANGE_FIRST || sel == RANGE_SECOND) begin
        n = count / 2;
        start = (sel == RANGE_SECOND) ? n : 0;
      end
      for (int i = 0; i < n; i++) begin
        x = adc_mem[start + i];
        y = dac_mem[start + i];
        sx += x; sx2 += x * x; sy += y; sxy += x * y;
      end
      r.icpt = 0;
      r.status = FIT_OK;
      r.used = n[6:0];
      r.ovf = ovf;
      if (n < 2) begin
        r.status = FIT_FEW;
      end else begin
        den = $signed(128'(n)) * sx2 - sx * sx;
        if (den == 0) begin
          r.status = FIT_ZERO_DEN;
        end else begin
          num = sy * sx2 - sx * sxy;
          neg = num[127] != den[127];
          if (num < 0) num = -num;
          if (den < 0) den = -den;
          q = $signed($unsigned(num << 8) / $unsigned(den));
          if (!neg) r.icpt = (q > 128'sh7FFFFFFF) ? 32'h7FFFFFFF : q[31:0];
          else r.icpt = (q > 128'sh80000000) ? 32'h80000000 : -q[31:0];
        end
      end
      return r;
    endfunction

    // Note an accepted point
    function void note_point(logic signed [23:0] a, logic signed [19:0] d, logic last);
      if (count < NPTS) begin
        adc_mem[count] = a;
        dac_mem[count] = d;
        count++;
      end else begin
        ovf = 1;
      end
      if (last) begin
        pending = {pending, compute_fit()};
        clear_set();
      end
    endfunction

    function void check_fit(fit_res_t got);
      fit_res_t want;
      if (pending.size() == 0) begin
        report_mismatch("result with no fit pending");
        return;
      end
      want = pending.pop_front();
      if (got.icpt !== want.icpt)
        report_mismatch($sformatf("intercept %0d, want %0d", got.icpt, want.icpt));
      if (got.status !== want.status)
        report_mismatch($sformatf("fit_status %0d, want %0d", got.status, want.status));
      if (got.used !== want.used)
        report_mismatch($sformatf("points_used %0d, want %0d", got.used, want.used));
      if (got.ovf !== want.ovf)
        report_mismatch($sformatf("store_overflow %0b, want %0b", got.ovf, want.ovf));
    endfunction

    function void report_mismatch(string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      errors++;
    endfunction
  endclass

  logic               clk_i = 0;
  logic               rst_ni = 0;
  logic               in_valid_i = 0;
  logic               in_stall_o;
  logic signed [23:0] adc_sample_i = 0;
  logic signed [19:0] dac_code_i = 0;
  logic               last_point_i = 0;
  logic               cfg_we_i = 0;
  logic [1:0]         cfg_wdata_i = 0;
  logic               out_valid_o;
  logic               out_stall_i = 0;
  logic signed [31:0] intercept_o;
  logic [1:0]         fit_status_o;
  logic [6:0]         points_used_o;
  logic               store_overflow_o;

  int unsigned    send_idle_pct = 0;
  int unsigned    recv_stall_pct = 0;
  fit_scoreboard  fit_sb = new();

  least_squares_zero_intercept dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .adc_sample_i, .dac_code_i,
    .last_point_i, .cfg_we_i, .cfg_wdata_i, .out_valid_o, .out_stall_i,
    .intercept_o, .fit_status_o, .points_used_o, .store_overflow_o
  );

  always begin
    #4 clk_i = 1;
    #4 clk_i = 0;
  end

  // Sample results at the rising edge, vary the receiver stall at the falling
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      fit_sb.check_fit({intercept_o, fit_status_o, points_used_o, store_overflow_o});
  end

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  // Drive one point and wait for it to be taken; valid stays up for the next
  task automatic send_point(logic signed [23:0] a, logic signed [19:0] d, logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 0;
      @(negedge clk_i);
    end
    in_valid_i   <= 1;
    adc_sample_i <= a;
    dac_code_i   <= d;
    last_point_i <= last;
    do @(posedge clk_i); while (in_stall_o);
    fit_sb.note_point(a, d, last);
    @(negedge clk_i);
  endtask

  // Drop the input valid once a run of points is over
  task automatic drop_input();
    in_valid_i <= 0;
  endtask

  // Wait until every fit has arrived plus the fit latency, then write the range
  task automatic write_range(logic [1:0] sel);
    drop_input();
    while (fit_sb.pending.size() != 0) @(negedge clk_i);
    repeat (300) @(negedge clk_i);
    cfg_we_i    <= 1;
    cfg_wdata_i <= sel;
    @(negedge clk_i);
    cfg_we_i <= 0;
    fit_sb.sel = sel;
  endtask

  // Send a set of points in one random style: full range, small ADC ranges, extremes or ADC 0 to 3
  task automatic send_set(int unsigned n);
    logic signed [23:0] a;
    logic signed [19:0] d;
    int unsigned style;
    style = $urandom_range(3);
    for (int i = 0; i < n; i++) begin
      case (style)
        0: begin
          a = 24'($urandom);
          d = 20'($urandom);
        end
        1: begin
          a = 24'(int'($urandom_range(2000)) - 1000);
          d = 20'(int'($urandom_range(400)) - 200 + int'(a) / 8);
        end
        2: begin
          a = ($urandom_range(1)) ? 24'sh7FFFFF : 24'sh800000;
          d = ($urandom_range(1)) ? 20'sh7FFFF : 20'sh80000;
        end
        default: begin
          a = 24'($urandom_range(3));
          d = 20'($urandom);
        end
      endcase
      send_point(a, d, i == n - 1);
    end
  endtask

  initial begin
    int unsigned sent;
    int unsigned n;
    fit_sb.errors = 0;
    fit_sb.sel = RANGE_ALL;
    fit_sb.clear_set();
    repeat (12) @(negedge clk_i);
    rst_ni <= 1;
    @(negedge clk_i);

    // Directed: single point, equal ADC values, extremes, overflow, odd halves
    send_point(24'sh7FFFFF, 20'sh7FFFF, 1'b1);
    send_point(24'sd5, 20'sd10, 1'b0);
    send_point(24'sd5, -20'sd3, 1'b1);
    send_point(24'sh800000, 20'sh80000, 1'b0);
    send_point(24'sh7FFFFF, 20'sh7FFFF, 1'b0);
    send_point(24'sd0, 20'sh80000, 1'b1);
    send_point(24'sd1, 20'sd0, 1'b0);
    send_point(24'sh800000, 20'sh7FFFF, 1'b1);
    send_set(NPTS + 3);
    write_range(RANGE_FIRST);
    send_set(5);
    send_set(3);
    write_range(RANGE_SECOND);
    send_set(7);
    send_set(NPTS + 1);
    write_range(2'd3);
    send_set(4);

    // Random phases of idling, with the range changed between phases
    sent = 0;
    for (int ph = 0; ph < 8; ph++) begin
      write_range(2'(ph % 4));
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 77; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 77; end
        default: begin send_idle_pct = 38; recv_stall_pct = 38; end
      endcase
      while (sent < (ph + 1) * 30) begin
        n = ($urandom_range(15) == 0) ? NPTS + $urandom_range(4) : $urandom_range(1, 10);
        send_set(n);
        sent += n;
      end
    end

    drop_input();
    while (fit_sb.pending.size() != 0) @(negedge clk_i);
    repeat (300) @(negedge clk_i);
    if (fit_sb.errors == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #20ms;
    $display("end of test: mismatches");
    $finish;
  end
endmodule
